@@ design/lirs_pkg.sv @@
// Package for the linear interpolation resampler.
// Holds shared widths, register indexes, the front-end state type and the command type.
// No dependencies.
`timescale 1ns / 1ps

package lirs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 20;
  localparam int FRAC_MAX_W = 24;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  localparam logic REG_STEP   = 1'b0;
  localparam logic REG_BYPASS = 1'b1;

  localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -18'sd32768;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PASS,
    FS_INTERP
  } front_state_t;

  // One output to compute: a + (b - a) * pos, pos in FRAC_BITS fraction bits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [FRAC_MAX_W-1:0]      pos;
    logic                       last;
  } cmd_t;

endpackage

@@ design/linear_interp_resampler_unit.sv @@
// Top level of the linear interpolation sample rate converter.
// Holds the APB register file and connects front end, command queue and back end.
// Depends on lirs_pkg, lirs_front, lirs_fifo, lirs_back.
`timescale 1ns / 1ps

// An input transaction is taken when the front end is idle. A priming sample
// or one that falls in a downsampling gap gives no result and leaves the front end idle, ready
// for the next input. Otherwise the front end issues one command per result (1 in bypass, up to
// MAX_UPSAMPLE when upsampling), one a cycle while the command queue is not full, and then
// returns to idle. Results leave through the command queue, the multiply stage and the
// round/saturate output register; the four-entry command queue lets the input side run on
// while the output side stalls.
module linear_interp_resampler_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lirs_pkg::PADDR_W-1:0]         paddr,
  input  logic [lirs_pkg::PDATA_W-1:0]         pwdata,
  output logic [lirs_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic signed [lirs_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import lirs_pkg::*;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << FRAC_BITS);

  logic [STEP_W-1:0] step;
  logic              bypass;
  logic              reg_idx;
  logic              wr_en;
  logic              push;
  logic              full;
  logic              empty;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              pop_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= STEP_RESET;
      bypass <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STEP:   step   <= pwdata[STEP_W-1:0];
        REG_BYPASS: bypass <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP:   prdata = PDATA_W'(step);
      REG_BYPASS: prdata = PDATA_W'(bypass);
      default:    prdata = '0;
    endcase
  end

  lirs_front #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .bypass   (bypass),
    .sample_in(sample_in),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .push     (push),
    .cmd      (push_cmd),
    .full     (full)
  );

  lirs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .empty   (empty)
  );

  lirs_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .last      (last)
  );

endmodule

@@ design/lirs_front.sv @@
// Front end of the resampler: accepts input transactions, primes, skips gaps
// and walks the fractional position, issuing one interpolation command per cycle while the queue is not full.
// Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_front #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [lirs_pkg::STEP_W-1:0]          step,
  input  logic                                 bypass,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic                                 push,
  output lirs_pkg::cmd_t                       cmd,
  input  logic                                 full
);
  import lirs_pkg::*;

  localparam int POS_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [POS_W-1:0] ONE_POS = POS_W'(64'd1 << FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_UPSAMPLE - 1);

  front_state_t              state, state_next;
  logic signed [SAMPLE_W-1:0] prev, prev_next;
  logic signed [SAMPLE_W-1:0] cur, cur_next;
  logic [POS_W-1:0]           position, position_next;
  logic                       primed, primed_next;
  logic [CNT_W-1:0]           count, count_next;
  logic [POS_W-1:0]           sum;
  logic                       done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FS_IDLE;
      prev     <= '0;
      position <= '0;
      primed   <= 1'b0;
      count    <= '0;
    end else begin
      state    <= state_next;
      prev     <= prev_next;
      position <= position_next;
      primed   <= primed_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  assign sum  = position + POS_W'(step);
  assign done = (sum >= ONE_POS) || (count == CNT_LAST);

  always_comb begin
    state_next    = state;
    prev_next     = prev;
    cur_next      = cur;
    position_next = position;
    primed_next   = primed;
    count_next    = count;
    in_ready      = 1'b0;
    push          = 1'b0;
    cmd.a         = prev;
    cmd.b         = cur;
    cmd.pos       = FRAC_MAX_W'(position[FRAC_BITS-1:0]);
    cmd.last      = done;
    case (state)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_next = sample_in;
          if (bypass) begin
            state_next = FS_PASS;
          end else if (!primed) begin
            prev_next     = sample_in;
            position_next = '0;
            primed_next   = 1'b1;
          end else if (position >= ONE_POS) begin
            prev_next     = sample_in;
            position_next = position - ONE_POS;
          end else begin
            count_next = '0;
            state_next = FS_INTERP;
          end
        end
      end
      FS_PASS: begin
        cmd.a    = cur;
        cmd.pos  = '0;
        cmd.last = 1'b1;
        if (!full) begin
          push        = 1'b1;
          prev_next   = cur;
          primed_next = 1'b1;
          state_next  = FS_IDLE;
        end
      end
      FS_INTERP: begin
        if (!full) begin
          push = 1'b1;
          if (done) begin
            position_next = (sum >= ONE_POS) ? (sum - ONE_POS) : '0;
            prev_next     = cur;
            state_next    = FS_IDLE;
          end else begin
            position_next = sum;
            count_next    = count + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

endmodule

@@ design/lirs_fifo.sv @@
// Command queue between the resampler front end and the arithmetic back end.
// Small register-based FIFO with first-word fall-through.
// Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lirs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output lirs_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import lirs_pkg::*;

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (fill == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ design/lirs_back.sv @@
// Back end of the resampler: multiply stage and round/saturate output register.
// Pops commands from the queue and presents results on the output channel.
// Depends on lirs_pkg.
`timescale 1ns / 1ps

module lirs_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  lirs_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lirs_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 last
);
  import lirs_pkg::*;

  localparam int PROD_W = SAMPLE_W + 1 + FRAC_MAX_W + 1;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(64'd1 << (FRAC_BITS - 1));

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [PROD_W-1:0]   s1_prod;
  logic                       s1_last;
  logic                       s1_en;
  logic                       s2_load;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [SAMPLE_W+1:0] quot;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [SAMPLE_W-1:0] sat;

  assign diff    = {cmd.b[SAMPLE_W-1], cmd.b} - {cmd.a[SAMPLE_W-1], cmd.a};
  assign prod    = diff * $signed({1'b0, cmd.pos});
  assign s2_load = !out_valid || out_ready;
  assign s1_en   = !s1_valid || s2_load;
  assign cmd_pop = cmd_valid && s1_en;

  assign rounded = s1_prod + RND;
  assign quot    = rounded[FRAC_BITS+SAMPLE_W+1:FRAC_BITS];
  assign sum     = quot + {{2{s1_a[SAMPLE_W-1]}}, s1_a};

  always_comb begin
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= cmd_valid;
      end
      if (s2_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_a    <= cmd.a;
      s1_prod <= prod;
      s1_last <= cmd.last;
    end
    if (s2_load && s1_valid) begin
      sample_out <= sat;
      last       <= s1_last;
    end
  end

endmodule

@@ design/lirs_checker.sv @@
// Port-level checks for the linear interpolation resampler, bound to the top level.
// Depends on linear_interp_resampler_unit.
`timescale 1ns / 1ps

module lirs_checker #(
  parameter int MAX_UPSAMPLE = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample_out,
  input logic        last,
  input logic        pready
);

  localparam int RUN_W = $clog2(MAX_UPSAMPLE + 1);

  logic [RUN_W-1:0] run;

  // outputs seen since the last transaction marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (out_valid && out_ready) begin
      run <= last ? '0 : run + RUN_W'(1);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last))
    else $error("stalled output transaction changed");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |-> run < RUN_W'(MAX_UPSAMPLE - 1))
    else $error("too many results for one input transaction");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind linear_interp_resampler_unit lirs_checker #(
  .MAX_UPSAMPLE(MAX_UPSAMPLE)
) u_lirs_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for linear_interp_resampler_unit: APB setup, stream driver and monitor.
// A built-in predictor of the resampler checks every output transaction in order.
// Depends on lirs_pkg and linear_interp_resampler_unit.
`timescale 1ns / 1ps

module tb;
  import lirs_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int MAX_UP = 8;
  localparam int unsigned ONE_POS = 1 << FRAC_BITS;
  localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 36;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       lst;
  } lerp_res_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic last;
  logic out_valid;
  logic out_ready = 1'b0;

  linear_interp_resampler_unit #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_in(sample_in),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_out(sample_out),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // resampler mirror
  logic [STEP_W-1:0] step_cfg = 20'd65536;
  logic bypass_cfg = 1'b0;
  logic signed [SAMPLE_W-1:0] prev_s = '0;
  int unsigned pos_acc = 0;
  bit primed = 1'b0;

  logic signed [SAMPLE_W-1:0] sample_q[$];
  lerp_res_t interp_q[$];

  int err_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int n_modes = 0;
  int cyc = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_stall = 0;
  int out_calm = 0;
  logic signed [SAMPLE_W-1:0] gen_last = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string what, input int e, input int a);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch (%s) at cycle %0d: expected %0d, got %0d", what, cyc, e, a);
  endtask

  function automatic int gap_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // expected outputs for one accepted input sample
  task automatic resample(input logic signed [SAMPLE_W-1:0] cur);
    int k;
    longint t;
    longint r;
    lerp_res_t res;
    bit more;
    if (bypass_cfg) begin
      res.smp = cur;
      res.lst = 1'b1;
      interp_q.push_back(res);
      prev_s = cur;
      primed = 1'b1;
      return;
    end
    if (!primed) begin
      prev_s = cur;
      pos_acc = 0;
      primed = 1'b1;
      return;
    end
    k = 0;
    while (pos_acc < ONE_POS && k < MAX_UP) begin
      t = (longint'(cur) - longint'(prev_s)) * longint'(pos_acc) + HALF_LSB;
      r = longint'(prev_s) + (t >>> FRAC_BITS);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      more = (pos_acc + step_cfg < ONE_POS) && (k + 1 < MAX_UP);
      res.smp = r[SAMPLE_W-1:0];
      res.lst = !more;
      interp_q.push_back(res);
      k++;
      pos_acc += step_cfg;
    end
    if (pos_acc >= ONE_POS) pos_acc -= ONE_POS;
    else pos_acc = 0;
    prev_s = cur;
  endtask

  task automatic check_result(input logic signed [SAMPLE_W-1:0] got_s, input logic got_l);
    lerp_res_t e;
    n_out++;
    if (interp_q.size() == 0) begin
      note_error("unexpected output", 0, got_s);
      return;
    end
    e = interp_q.pop_front();
    if (got_s !== e.smp) note_error("sample_out", e.smp, got_s);
    if (got_l !== e.lst) note_error("last", e.lst, got_l);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resample(sample_in);
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_in <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (in_calm > 0) in_calm--;
          else if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(15, 60);
          in_gap = gap_len(in_calm > 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(sample_out, last);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_calm > 0) out_calm--;
        else if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 80);
        out_stall = gap_len(out_calm > 0);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cyc, interp_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data,
                           input logic [PDATA_W-1:0] mask);
    logic [PDATA_W-1:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== (data & mask)) note_error("register readback", data & mask, rd);
  endtask

  task automatic set_mode(input logic [STEP_W-1:0] st, input logic byp);
    write_reg({REG_STEP, 2'b00}, {12'($urandom), st}, 32'h000F_FFFF);
    write_reg({REG_BYPASS, 2'b00}, {31'($urandom), byp}, 32'h0000_0001);
    step_cfg = st;
    bypass_cfg = byp;
    n_modes++;
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || in_valid || interp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: gen_last = 16'sh7FFF;
        1: gen_last = 16'sh8000;
        2: gen_last = 16'sh0000;
        default: gen_last = 16'shFFFF;
      endcase
    end else if (r < 40) begin
      gen_last = gen_last + 16'($urandom_range(0, 128)) - 16'sd64;
    end else begin
      gen_last = 16'($urandom);
    end
    return gen_last;
  endfunction

  initial begin
    logic [STEP_W-1:0] st;
    logic byp;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    n_modes = 1;

    // reset settings: priming, then unit step
    sample_q = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    settle();
    // half steps exercise rounding of halves in both signs
    set_mode(20'd32768, 1'b0);
    sample_q = '{16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd1};
    settle();
    // step of one eighth: exactly eight outputs across full-scale swings
    set_mode(20'd8192, 1'b0);
    sample_q = '{16'sh8000, 16'sh7FFF, 16'sh8000};
    settle();
    // zero step hits the output cap with the interval unused
    set_mode(20'd0, 1'b0);
    sample_q = '{16'sd12345, -16'sd12345};
    settle();
    // step of eight: mostly downsampling gaps
    set_mode(20'd524288, 1'b0);
    sample_q = '{16'sd100, 16'sd200, -16'sd300, 16'sh7FFF, 16'sh8000, 16'sd7, 16'sd8, -16'sd9};
    settle();
    set_mode(20'($urandom), 1'b1);
    sample_q = '{16'sh7FFF, 16'sh8000, 16'sd5};
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0: st = 20'd8192;
        1: st = 20'd524288;
        2: st = 20'd65536;
        3, 4: st = 20'($urandom_range(8192, 65535));
        5, 6: st = 20'($urandom_range(65536, 524288));
        7: st = 20'($urandom);
        default: st = 20'($urandom_range(0, 8191));
      endcase
      if (p == 0) st = 20'd8192;
      if (p == 1) st = 20'd524288;
      if (p == 2) st = 20'hFFFFF;
      byp = (p == 3) || ($urandom_range(0, 9) == 0);
      set_mode(st, byp);
      for (int i = 0; i < PHASE_ITEMS; i++) sample_q.push_back(rand_sample());
      settle();
    end

    $display("covered %0d input samples and %0d output samples over %0d register settings",
             n_in, n_out, n_modes);
    $display("%0d mismatches found", err_cnt);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lirs_pkg.sv
design/lirs_front.sv
design/lirs_fifo.sv
design/lirs_back.sv
design/linear_interp_resampler_unit.sv
design/lirs_checker.sv
tb/tb.sv
